>>> rtl/vcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcl_pkg
// Shared widths, types and register codes of the velocity command limiter.
// ----------------------------------------------------------------------------
package vcl_pkg;

   // value width of desired, measured and command fields (signed fixed point)
   localparam int VALUE_W = 24;
   // width of every limit register
   localparam int REG_W = 23;
   // working width of the limiting arithmetic
   localparam int CALC_W = ((VALUE_W > REG_W) ? VALUE_W : REG_W) + 3;
   // radicand and remainder widths of the square root chain
   localparam int RAD_W = 2 * VALUE_W;
   localparam int REM_W = VALUE_W + 1;

   localparam int REQ_BITS = 3 * VALUE_W + 1;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VALUE_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIN_MAX_SPEED = 3'd0,
      CSR_LIN_MAX_STEP  = 3'd1,
      CSR_LIN_MIN_SPEED = 3'd2,
      CSR_ANG_MAX_RATE  = 3'd3,
      CSR_ANG_MAX_STEP  = 3'd4,
      CSR_ANG_MIN_RATE  = 3'd5
   } csr_index_type;

   localparam logic [REG_W-1:0] LIN_MAX_SPEED_RST = REG_W'(32768);
   localparam logic [REG_W-1:0] LIN_MAX_STEP_RST  = REG_W'(6554);
   localparam logic [REG_W-1:0] LIN_MIN_SPEED_RST = REG_W'(0);
   localparam logic [REG_W-1:0] ANG_MAX_RATE_RST  = REG_W'(65536);
   localparam logic [REG_W-1:0] ANG_MAX_STEP_RST  = REG_W'(13107);
   localparam logic [REG_W-1:0] ANG_MIN_RATE_RST  = REG_W'(0);

   typedef enum logic {
      MODE_LINEAR  = 1'b0,
      MODE_ANGULAR = 1'b1
   } mode_type;

   typedef struct packed {
      logic [REG_W-1:0] lin_max_speed;
      logic [REG_W-1:0] lin_max_step;
      logic [REG_W-1:0] lin_min_speed;
      logic [REG_W-1:0] ang_max_rate;
      logic [REG_W-1:0] ang_max_step;
      logic [REG_W-1:0] ang_min_rate;
   } cfg_type;

   // fields of a command that ride along the square root chain
   typedef struct packed {
      mode_type                   opcode;
      logic signed [VALUE_W-1:0]  desired;
      logic signed [VALUE_W-1:0]  measured_x;
   } item_type;

   // contents of one square root cell
   typedef struct packed {
      item_type             item;
      logic [RAD_W-1:0]     rad;
      logic [REM_W-1:0]     rem;
      logic [VALUE_W-1:0]   root;
   } root_data_type;

endpackage

`default_nettype wire

>>> rtl/vcl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcl_front
// Unpacks a request beat and forms the sum of squares of the measured
// velocity over three stages: magnitudes, squares, sum.
// ----------------------------------------------------------------------------
module vcl_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // opcode, desired, measured_x, measured_y, zero fill
   input  wire logic [vcl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output      logic                                out_valid,
   output      vcl_pkg::root_data_type              out_data,
   input  wire logic                                out_ready
);

   localparam int V = vcl_pkg::VALUE_W;

   vcl_pkg::item_type        item_req;
   logic signed [V-1:0]      meas_y;

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                     move1, move2, move3;
   vcl_pkg::item_type        s1_item_ff, s2_item_ff, s3_item_ff;
   logic [V-1:0]             ax_ff, ay_ff, ax_in, ay_in;
   logic [2*V-1:0]           sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [2*V-1:0]           rad_ff, rad_in;

   assign item_req.opcode     = vcl_pkg::mode_type'(req_tdata[0]);
   assign item_req.desired    = req_tdata[V:1];
   assign item_req.measured_x = req_tdata[2*V:V+1];
   assign meas_y              = req_tdata[3*V:2*V+1];

   assign move3      = !s3_valid_ff || out_ready;
   assign move2      = !s2_valid_ff || move3;
   assign move1      = !s1_valid_ff || move2;
   assign req_tready = move1;

   // magnitude of the most negative value still fits unsigned
   assign ax_in  = item_req.measured_x[V-1] ? V'(-item_req.measured_x)
                                             : item_req.measured_x;
   assign ay_in  = meas_y[V-1] ? V'(-meas_y) : meas_y;
   assign sqx_in = ax_ff * ax_ff;
   assign sqy_in = ay_ff * ay_ff;
   assign rad_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (move1) s1_valid_ff <= req_tvalid;
         if (move2) s2_valid_ff <= s1_valid_ff;
         if (move3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         s1_item_ff <= item_req;
         ax_ff      <= ax_in;
         ay_ff      <= ay_in;
      end
      if (move2) begin
         s2_item_ff <= s1_item_ff;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
      end
      if (move3) begin
         s3_item_ff <= s2_item_ff;
         rad_ff     <= rad_in;
      end
   end

   assign out_valid     = s3_valid_ff;
   assign out_data.item = s3_item_ff;
   assign out_data.rad  = rad_ff;
   assign out_data.rem  = '0;
   assign out_data.root = '0;

endmodule

`default_nettype wire

>>> rtl/vcl_root_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcl_root_cell
// One cell of the square root chain: takes the top two radicand bits and
// settles one root bit by a trial subtract, then hands on to the next cell.
// ----------------------------------------------------------------------------
module vcl_root_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire vcl_pkg::root_data_type  in_data,
   output      logic                    in_ready,
   output      logic                    out_valid,
   output      vcl_pkg::root_data_type  out_data,
   input  wire logic                    out_ready
);

   localparam int V = vcl_pkg::VALUE_W;
   localparam int RW = vcl_pkg::RAD_W;
   localparam int MW = vcl_pkg::REM_W;

   logic                    valid_ff;
   vcl_pkg::root_data_type  data_ff, data_in;
   logic [MW:0]             rem_sh, trial, diff;
   logic                    fits;

   assign in_ready = !valid_ff || out_ready;

   assign rem_sh = {in_data.rem[MW-2:0], in_data.rad[RW-1:RW-2]};
   assign trial  = {in_data.root, 2'b01};
   assign diff   = rem_sh - trial;
   assign fits   = rem_sh >= trial;

   always_comb begin
      data_in.item = in_data.item;
      data_in.rad  = {in_data.rad[RW-3:0], 2'b00};
      if (fits) begin
         data_in.rem  = diff[MW-1:0];
         data_in.root = {in_data.root[V-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh[MW-1:0];
         data_in.root = {in_data.root[V-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.rem <= {data_ff.root, 1'b0})
      else $error("square root remainder out of bound");

endmodule

`default_nettype wire

>>> rtl/vcl_limit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcl_limit
// Clamps the desired value, limits its step from the measured value and
// clamps the command magnitude, over four stages ending in the result beat.
// ----------------------------------------------------------------------------
module vcl_limit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire vcl_pkg::cfg_type                cfg,
   input  wire logic                            in_valid,
   input  wire vcl_pkg::root_data_type          in_data,
   output      logic                            in_ready,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // command, zero fill
   output      logic [vcl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int V = vcl_pkg::VALUE_W;
   localparam int C = vcl_pkg::CALC_W;
   localparam int R = vcl_pkg::REG_W;
   localparam logic signed [C-1:0] OUT_HI = {{(C-V+1){1'b0}}, {(V-1){1'b1}}};
   localparam logic signed [C-1:0] OUT_LO = {{(C-V+1){1'b1}}, {(V-1){1'b0}}};

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  move1, move2, move3, move4;
   vcl_pkg::mode_type     op1_ff, op2_ff, op3_ff;
   logic signed [C-1:0]   meas1_ff, meas1_in, des1_ff, des1_in;
   logic signed [C-1:0]   meas2_ff, inc2_ff, inc2_in;
   logic signed [C-1:0]   cmd3_ff, cmd3_in;
   logic signed [C-1:0]   cmd4_in, lim4;
   logic [V-1:0]          cmd4_ff;
   logic signed [C-1:0]   des_x, vmax1, step2, diff2, vmax4, vmin4;
   logic                  angular1, angular2, angular4;

   assign move4    = !v4_ff || rsp_tready;
   assign move3    = !v3_ff || move4;
   assign move2    = !v2_ff || move3;
   assign move1    = !v1_ff || move2;
   assign in_ready = move1;

   // stage 1: measured value and desired clamp
   assign angular1 = in_data.item.opcode == vcl_pkg::MODE_ANGULAR;
   assign des_x    = {{(C-V){in_data.item.desired[V-1]}}, in_data.item.desired};
   assign vmax1    = angular1 ? {{(C-R){1'b0}}, cfg.ang_max_rate}
                              : {{(C-R){1'b0}}, cfg.lin_max_speed};

   always_comb begin
      if (angular1) begin
         meas1_in = {{(C-V){in_data.item.measured_x[V-1]}}, in_data.item.measured_x};
      end else begin
         meas1_in = {{(C-V){1'b0}}, in_data.root};
      end
      if (des_x > vmax1) begin
         des1_in = vmax1;
      end else if (des_x < -vmax1) begin
         des1_in = -vmax1;
      end else begin
         des1_in = des_x;
      end
   end

   // stage 2: step limit
   assign angular2 = op1_ff == vcl_pkg::MODE_ANGULAR;
   assign step2    = angular2 ? {{(C-R){1'b0}}, cfg.ang_max_step}
                              : {{(C-R){1'b0}}, cfg.lin_max_step};
   assign diff2    = des1_ff - meas1_ff;

   always_comb begin
      if (diff2 > step2) begin
         inc2_in = step2;
      end else if (diff2 < -step2) begin
         inc2_in = -step2;
      end else begin
         inc2_in = diff2;
      end
   end

   // stage 3: stepped command
   assign cmd3_in = meas2_ff + inc2_ff;

   // stage 4: magnitude clamp, zero goes to plus the minimum
   assign angular4 = op3_ff == vcl_pkg::MODE_ANGULAR;
   assign vmax4    = angular4 ? {{(C-R){1'b0}}, cfg.ang_max_rate}
                              : {{(C-R){1'b0}}, cfg.lin_max_speed};
   assign vmin4    = angular4 ? {{(C-R){1'b0}}, cfg.ang_min_rate}
                              : {{(C-R){1'b0}}, cfg.lin_min_speed};

   always_comb begin
      if (cmd3_ff > vmax4) begin
         lim4 = vmax4;
      end else if (cmd3_ff < -vmax4) begin
         lim4 = -vmax4;
      end else if (cmd3_ff >= 0 && cmd3_ff < vmin4) begin
         lim4 = vmin4;
      end else if (cmd3_ff < 0 && cmd3_ff > -vmin4) begin
         lim4 = -vmin4;
      end else begin
         lim4 = cmd3_ff;
      end
      if (lim4 > OUT_HI) begin
         cmd4_in = OUT_HI;
      end else if (lim4 < OUT_LO) begin
         cmd4_in = OUT_LO;
      end else begin
         cmd4_in = lim4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (move1) v1_ff <= in_valid;
         if (move2) v2_ff <= v1_ff;
         if (move3) v3_ff <= v2_ff;
         if (move4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         op1_ff   <= in_data.item.opcode;
         meas1_ff <= meas1_in;
         des1_ff  <= des1_in;
      end
      if (move2) begin
         op2_ff   <= op1_ff;
         meas2_ff <= meas1_ff;
         inc2_ff  <= inc2_in;
      end
      if (move3) begin
         op3_ff  <= op2_ff;
         cmd3_ff <= cmd3_in;
      end
      if (move4) begin
         cmd4_ff <= cmd4_in[V-1:0];
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(vcl_pkg::RSP_TDATA_W-V){1'b0}}, cmd4_ff};

   // linear speed comes from the root and is never negative
   a_lin_meas_pos: assert property (@(posedge clock) disable iff (reset)
      v1_ff && op1_ff == vcl_pkg::MODE_LINEAR |-> meas1_ff >= 0)
      else $error("negative linear speed");

   // a full output stage that is not taken holds back the stage before it
   a_stall: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rsp_tready && v3_ff |=> v3_ff && v4_ff)
      else $error("command lost under stall");

endmodule

`default_nettype wire

>>> rtl/velocity_command_limiter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_command_limiter_top
// Velocity command limiter: desired clamp, step limit from the measured
// speed (root of x and y squares in linear mode) and magnitude clamp.
// ----------------------------------------------------------------------------
// path: request beat to response beat through 3 front stages, one square
//   root cell per root bit and 4 limiting stages
// throughput: one command per cycle while rsp_tready is high; every stage
//   moves on when its successor has room; bubbles close in a response stall
// reset: limit registers return to their reset values, all stages empty
module velocity_command_limiter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // opcode, desired, measured_x, measured_y, zero fill
   input  wire logic [vcl_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // command, zero fill
   output      logic [vcl_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [vcl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [vcl_pkg::REG_W-1:0]           csr_wdata
);

   localparam int V = vcl_pkg::VALUE_W;

   vcl_pkg::cfg_type         cfg_ff;
   logic                     chain_valid [V+1];
   logic                     chain_ready [V+1];
   vcl_pkg::root_data_type   chain_data  [V+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lin_max_speed <= vcl_pkg::LIN_MAX_SPEED_RST;
         cfg_ff.lin_max_step  <= vcl_pkg::LIN_MAX_STEP_RST;
         cfg_ff.lin_min_speed <= vcl_pkg::LIN_MIN_SPEED_RST;
         cfg_ff.ang_max_rate  <= vcl_pkg::ANG_MAX_RATE_RST;
         cfg_ff.ang_max_step  <= vcl_pkg::ANG_MAX_STEP_RST;
         cfg_ff.ang_min_rate  <= vcl_pkg::ANG_MIN_RATE_RST;
      end else if (csr_wr_en) begin
         case (vcl_pkg::csr_index_type'(csr_index))
            vcl_pkg::CSR_LIN_MAX_SPEED: cfg_ff.lin_max_speed <= csr_wdata;
            vcl_pkg::CSR_LIN_MAX_STEP:  cfg_ff.lin_max_step  <= csr_wdata;
            vcl_pkg::CSR_LIN_MIN_SPEED: cfg_ff.lin_min_speed <= csr_wdata;
            vcl_pkg::CSR_ANG_MAX_RATE:  cfg_ff.ang_max_rate  <= csr_wdata;
            vcl_pkg::CSR_ANG_MAX_STEP:  cfg_ff.ang_max_step  <= csr_wdata;
            vcl_pkg::CSR_ANG_MIN_RATE:  cfg_ff.ang_min_rate  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   vcl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (chain_valid[0]),
      .out_data   (chain_data[0]),
      .out_ready  (chain_ready[0])
   );

   // one cell per root bit, most significant first
   for (genvar i = 0; i < V; i++) begin : g_cell
      vcl_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .in_ready  (chain_ready[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   vcl_limit u_limit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (chain_valid[V]),
      .in_data    (chain_data[V]),
      .in_ready   (chain_ready[V]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat right after reset");

endmodule

`default_nettype wire
